// ===== rtl/core/pnew_pkg.sv =====
package pnew_pkg;

  // Exp table: EXP_TABLE_SIZE+1 points over [0,16] at Q1.16 (1.0 = 65536)
  localparam int EXP_TABLE_SIZE = 256;
  localparam int EXP_IDX_W      = $clog2(EXP_TABLE_SIZE);
  localparam int EXP_W          = 17;

  localparam int PIX_W    = 24;
  localparam int DIST_W   = 18;
  localparam int SUM_W    = 48;
  localparam int PAIR_W   = 23;
  localparam int BETA_W   = 32;
  localparam int WEIGHT_W = 24;
  localparam int GAMMA_W  = 16;
  localparam int IWIDTH_W = 11;

  localparam logic [15:0] INV_SQRT2_Q16 = 16'd46341;

  // Configuration register indexes
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_GAMMA_SCALE = 1'b1;

  // Neighbour slots: left, up-left, up, up-right
  localparam int NB_LEFT    = 0;
  localparam int NB_UPLEFT  = 1;
  localparam int NB_UP      = 2;
  localparam int NB_UPRIGHT = 3;

  // exp(16/N) as a 25-term series in Q2.30, then its reciprocal step factor
  localparam logic [63:0] EXP_H   = (64'd1 << 34) / 64'(EXP_TABLE_SIZE);
  localparam logic [63:0] EXP_T0  = 64'd1 << 30;
  localparam logic [63:0] EXP_T1  = ((EXP_T0 * EXP_H) >> 30) / 64'd1;
  localparam logic [63:0] EXP_T2  = ((EXP_T1 * EXP_H) >> 30) / 64'd2;
  localparam logic [63:0] EXP_T3  = ((EXP_T2 * EXP_H) >> 30) / 64'd3;
  localparam logic [63:0] EXP_T4  = ((EXP_T3 * EXP_H) >> 30) / 64'd4;
  localparam logic [63:0] EXP_T5  = ((EXP_T4 * EXP_H) >> 30) / 64'd5;
  localparam logic [63:0] EXP_T6  = ((EXP_T5 * EXP_H) >> 30) / 64'd6;
  localparam logic [63:0] EXP_T7  = ((EXP_T6 * EXP_H) >> 30) / 64'd7;
  localparam logic [63:0] EXP_T8  = ((EXP_T7 * EXP_H) >> 30) / 64'd8;
  localparam logic [63:0] EXP_T9  = ((EXP_T8 * EXP_H) >> 30) / 64'd9;
  localparam logic [63:0] EXP_T10 = ((EXP_T9 * EXP_H) >> 30) / 64'd10;
  localparam logic [63:0] EXP_T11 = ((EXP_T10 * EXP_H) >> 30) / 64'd11;
  localparam logic [63:0] EXP_T12 = ((EXP_T11 * EXP_H) >> 30) / 64'd12;
  localparam logic [63:0] EXP_T13 = ((EXP_T12 * EXP_H) >> 30) / 64'd13;
  localparam logic [63:0] EXP_T14 = ((EXP_T13 * EXP_H) >> 30) / 64'd14;
  localparam logic [63:0] EXP_T15 = ((EXP_T14 * EXP_H) >> 30) / 64'd15;
  localparam logic [63:0] EXP_T16 = ((EXP_T15 * EXP_H) >> 30) / 64'd16;
  localparam logic [63:0] EXP_T17 = ((EXP_T16 * EXP_H) >> 30) / 64'd17;
  localparam logic [63:0] EXP_T18 = ((EXP_T17 * EXP_H) >> 30) / 64'd18;
  localparam logic [63:0] EXP_T19 = ((EXP_T18 * EXP_H) >> 30) / 64'd19;
  localparam logic [63:0] EXP_T20 = ((EXP_T19 * EXP_H) >> 30) / 64'd20;
  localparam logic [63:0] EXP_T21 = ((EXP_T20 * EXP_H) >> 30) / 64'd21;
  localparam logic [63:0] EXP_T22 = ((EXP_T21 * EXP_H) >> 30) / 64'd22;
  localparam logic [63:0] EXP_T23 = ((EXP_T22 * EXP_H) >> 30) / 64'd23;
  localparam logic [63:0] EXP_T24 = ((EXP_T23 * EXP_H) >> 30) / 64'd24;
  localparam logic [63:0] EXP_SUM = EXP_T0 + EXP_T1 + EXP_T2 + EXP_T3 + EXP_T4 + EXP_T5
                                  + EXP_T6 + EXP_T7 + EXP_T8 + EXP_T9 + EXP_T10 + EXP_T11
                                  + EXP_T12 + EXP_T13 + EXP_T14 + EXP_T15 + EXP_T16
                                  + EXP_T17 + EXP_T18 + EXP_T19 + EXP_T20 + EXP_T21
                                  + EXP_T22 + EXP_T23 + EXP_T24;
  localparam logic [63:0] EXP_Q   = ((64'd1 << 60) + (EXP_SUM >> 1)) / EXP_SUM;

  typedef logic [EXP_W-1:0] exp_tab_t [0:EXP_TABLE_SIZE];

  typedef struct packed {
    logic                  cmd;
    logic                  last;
    logic [PIX_W-1:0]      pix;
    logic [3:0][PIX_W-1:0] nb;
    logic [3:0]            has;
  } item_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_RD_UP,
    F_RD_UR,
    F_PUSH
  } front_state_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DIST,
    B_ACC,
    B_X,
    B_LERP,
    B_GAMMA,
    B_WEIGHT,
    B_DSTART,
    B_DWAIT,
    B_OUT
  } back_state_t;

  // exp(-k*16/N) by repeated products of the one-step factor
  function automatic exp_tab_t build_exp_table();
    logic [63:0] cur;
    exp_tab_t    t;
    cur  = 64'd1 << 30;
    t[0] = EXP_W'((cur + 64'd8192) >> 14);
    for (int k = 1; k <= EXP_TABLE_SIZE; k++) begin
      cur  = (cur * EXP_Q + (64'd1 << 29)) >> 30;
      t[k] = EXP_W'((cur + 64'd8192) >> 14);
    end
    return t;
  endfunction

endpackage

// ===== rtl/core/pnew_front.sv =====
module pnew_front #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [23:0]                   s_tdata,
  input  logic                          s_tuser,
  input  logic                          s_tlast,
  input  logic [pnew_pkg::IWIDTH_W-1:0] image_width,
  input  logic                          full,
  output logic                          push,
  output pnew_pkg::item_t               item
);

  localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

  pnew_pkg::front_state_t state, state_next;

  logic [pnew_pkg::PIX_W-1:0] line_mem [0:MAX_WIDTH-1];
  logic [pnew_pkg::PIX_W-1:0] rdata;
  logic [CW-1:0]              raddr;

  logic [pnew_pkg::PIX_W-1:0] left_pixel;
  logic [pnew_pkg::PIX_W-1:0] upleft_pixel;
  logic [CW-1:0]              column_count;
  logic                       past_first_row;

  logic [pnew_pkg::PIX_W-1:0] pix_q;
  logic [pnew_pkg::PIX_W-1:0] up_q;
  logic                       cmd_q;
  logic                       last_q;
  logic [CW-1:0]              col_q;
  logic                       at_end_q;
  logic                       has_left_q;
  logic                       has_up_q;
  logic                       has_ur_q;

  logic [13:0]   w_eff;
  logic [CW-1:0] wm1;
  logic [CW-1:0] col_c;
  logic          accept;

  // effective width, clamped to [2, MAX_WIDTH]
  always_comb begin
    if (14'(image_width) < 14'd2) begin
      w_eff = 14'd2;
    end else if (14'(image_width) > 14'(MAX_WIDTH)) begin
      w_eff = 14'(MAX_WIDTH);
    end else begin
      w_eff = 14'(image_width);
    end
    wm1   = CW'(w_eff - 14'd1);
    col_c = (column_count > wm1) ? wm1 : column_count;
  end

  assign accept = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      pnew_pkg::F_IDLE:  if (s_tvalid) state_next = pnew_pkg::F_RD_UP;
      pnew_pkg::F_RD_UP: state_next = pnew_pkg::F_RD_UR;
      pnew_pkg::F_RD_UR: state_next = pnew_pkg::F_PUSH;
      pnew_pkg::F_PUSH:  if (!full) state_next = pnew_pkg::F_IDLE;
      default:           state_next = pnew_pkg::F_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    push     = 1'b0;
    raddr    = CW'(col_q + CW'(1));
    unique case (state)
      pnew_pkg::F_IDLE:  s_tready = 1'b1;
      pnew_pkg::F_RD_UP: raddr = col_q;
      pnew_pkg::F_RD_UR: ;
      pnew_pkg::F_PUSH:  push = !full;
      default:           ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnew_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // line store with one read and one write port: one read per cycle, write on push
  always_ff @(posedge clk) begin
    if (push) begin
      line_mem[col_q] <= pix_q;
    end
    rdata <= line_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_q      <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
      cmd_q      <= s_tuser;
      last_q     <= s_tlast;
      col_q      <= col_c;
      at_end_q   <= (col_c >= wm1);
      has_left_q <= (col_c != '0);
      has_up_q   <= past_first_row;
      has_ur_q   <= past_first_row && (col_c < wm1);
    end
    if (state == pnew_pkg::F_RD_UR) begin
      up_q <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel     <= '0;
      upleft_pixel   <= '0;
      column_count   <= '0;
      past_first_row <= 1'b0;
    end else if (push) begin
      if (last_q) begin
        left_pixel     <= '0;
        upleft_pixel   <= '0;
        column_count   <= '0;
        past_first_row <= 1'b0;
      end else begin
        left_pixel   <= pix_q;
        upleft_pixel <= up_q;
        if (at_end_q) begin
          column_count   <= '0;
          past_first_row <= 1'b1;
        end else begin
          column_count <= CW'(col_q + CW'(1));
        end
      end
    end
  end

  always_comb begin
    item.cmd                     = cmd_q;
    item.last                    = last_q;
    item.pix                     = pix_q;
    item.nb[pnew_pkg::NB_LEFT]    = left_pixel;
    item.nb[pnew_pkg::NB_UPLEFT]  = upleft_pixel;
    item.nb[pnew_pkg::NB_UP]      = up_q;
    item.nb[pnew_pkg::NB_UPRIGHT] = has_ur_q ? rdata : '0;
    item.has[pnew_pkg::NB_LEFT]    = has_left_q;
    item.has[pnew_pkg::NB_UPLEFT]  = has_left_q && has_up_q;
    item.has[pnew_pkg::NB_UP]      = has_up_q;
    item.has[pnew_pkg::NB_UPRIGHT] = has_ur_q;
  end

endmodule

// ===== rtl/core/pnew_queue.sv =====
module pnew_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  pnew_pkg::item_t wr_item,
  input  logic            pop,
  output pnew_pkg::item_t head,
  output logic            full,
  output logic            empty
);

  pnew_pkg::item_t slots [0:1];
  logic            wp;
  logic            rp;
  logic [1:0]      count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'd2);
  assign head  = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/core/pnew_div.sv =====
module pnew_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [38:0] num,
  input  logic [48:0] den,
  output logic        done,
  output logic [38:0] quo
);

  localparam int NW = 39;

  logic        busy;
  logic [5:0]  cnt;
  logic [49:0] rem;
  logic [48:0] den_q;
  logic [49:0] rem_sh;
  logic        ge;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem[48:0], quo[NW-1]};
  assign ge     = (rem_sh >= {1'b0, den_q});

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_q <= den;
      cnt   <= '0;
    end else if (busy) begin
      rem <= ge ? (rem_sh - {1'b0, den_q}) : rem_sh;
      quo <= {quo[NW-2:0], ge};
      cnt <= cnt + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'(NW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/pnew_back.sv =====
module pnew_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [pnew_pkg::GAMMA_W-1:0] gamma_scale,
  input  logic                         empty,
  input  pnew_pkg::item_t              head,
  output logic                         pop,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [127:0]                 m_tdata,
  output logic                         m_tuser
);

  localparam pnew_pkg::exp_tab_t EXP_TAB = pnew_pkg::build_exp_table();
  localparam int IW = pnew_pkg::EXP_IDX_W;

  pnew_pkg::back_state_t state, state_next;

  pnew_pkg::item_t cur;
  logic [1:0]      k;

  logic [pnew_pkg::DIST_W-1:0] d;
  logic [49:0]                 x;
  logic                        big;
  logic [pnew_pkg::EXP_W-1:0]  hi_q;
  logic [36:0]                 lerp;
  logic [32:0]                 gw;
  logic [3:0][23:0]            res;

  logic [pnew_pkg::SUM_W-1:0]  distance_sum;
  logic [pnew_pkg::PAIR_W-1:0] pair_count;
  logic [pnew_pkg::BETA_W-1:0] beta_value;
  logic [pnew_pkg::BETA_W-1:0] beta_res;
  logic                        beta_flag;

  logic                        div_start;
  logic                        div_done;
  logic [38:0]                 div_quo;
  logic                        out_load;

  logic [pnew_pkg::PIX_W-1:0]  nbk;
  logic [pnew_pkg::DIST_W-1:0] d_calc;
  logic [48:0]                 sum_add;
  logic [IW-1:0]               tab_i;
  logic [IW:0]                 tab_i1;
  logic [19:0]                 frac;
  logic [pnew_pkg::EXP_W-1:0]  t_hi;
  logic [pnew_pkg::EXP_W-1:0]  t_lo;
  logic [pnew_pkg::EXP_W-1:0]  e_val;
  logic [48:0]                 diag_prod;
  logic [23:0]                 w_val;
  logic [31:0]                 quo_sat;
  logic                        k_last;
  pnew_pkg::back_state_t       after_k;

  pnew_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   ({pair_count, 16'd0}),
    .den   ({distance_sum, 1'b0}),
    .done  (div_done),
    .quo   (div_quo)
  );

  // squared colour distance to the selected neighbour
  always_comb begin
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] ad;
    nbk    = cur.nb[k];
    d_calc = '0;
    for (int s = 0; s < 3; s++) begin
      a      = cur.pix[s*8 +: 8];
      b      = nbk[s*8 +: 8];
      ad     = (a > b) ? (a - b) : (b - a);
      d_calc = d_calc + pnew_pkg::DIST_W'(ad) * pnew_pkg::DIST_W'(ad);
    end
  end

  always_comb begin
    sum_add   = {1'b0, distance_sum} + 49'(d);
    tab_i     = x[19:20-IW];
    tab_i1    = (IW+1)'(tab_i) + (IW+1)'(1);
    frac      = {x[19-IW:0], IW'(0)};
    t_hi      = EXP_TAB[tab_i];
    t_lo      = EXP_TAB[tab_i1];
    e_val     = big ? '0 : (hi_q - pnew_pkg::EXP_W'(lerp >> 20));
    diag_prod = 49'(gw) * 49'(pnew_pkg::INV_SQRT2_Q16);
    w_val     = k[0] ? diag_prod[47:24] : gw[31:8];
    quo_sat   = (div_quo[38:32] != '0) ? '1 : div_quo[31:0];
    k_last    = (k == 2'd3);
    if (!k_last) begin
      after_k = pnew_pkg::B_DIST;
    end else if (!cur.cmd && cur.last) begin
      after_k = pnew_pkg::B_DSTART;
    end else begin
      after_k = pnew_pkg::B_OUT;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pnew_pkg::B_IDLE:   if (!empty) state_next = pnew_pkg::B_DIST;
      pnew_pkg::B_DIST: begin
        if (!cur.has[k]) begin
          state_next = after_k;
        end else if (cur.cmd) begin
          state_next = pnew_pkg::B_X;
        end else begin
          state_next = pnew_pkg::B_ACC;
        end
      end
      pnew_pkg::B_ACC:    state_next = after_k;
      pnew_pkg::B_X:      state_next = pnew_pkg::B_LERP;
      pnew_pkg::B_LERP:   state_next = pnew_pkg::B_GAMMA;
      pnew_pkg::B_GAMMA:  state_next = pnew_pkg::B_WEIGHT;
      pnew_pkg::B_WEIGHT: state_next = after_k;
      pnew_pkg::B_DSTART: begin
        state_next = (distance_sum == '0) ? pnew_pkg::B_OUT : pnew_pkg::B_DWAIT;
      end
      pnew_pkg::B_DWAIT:  if (div_done) state_next = pnew_pkg::B_OUT;
      pnew_pkg::B_OUT:    if (out_load) state_next = pnew_pkg::B_IDLE;
      default:            state_next = pnew_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      pnew_pkg::B_IDLE:   pop = !empty;
      pnew_pkg::B_DSTART: div_start = (distance_sum != '0);
      pnew_pkg::B_OUT:    out_load = !m_tvalid || m_tready;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pnew_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath: results registered between steps
  always_ff @(posedge clk) begin
    if (pop) begin
      cur       <= head;
      k         <= 2'd0;
      res       <= '0;
      beta_res  <= '0;
      beta_flag <= !head.cmd && head.last;
    end
    unique case (state)
      pnew_pkg::B_DIST: begin
        d <= d_calc;
        if (!cur.has[k]) k <= k + 2'd1;
      end
      pnew_pkg::B_ACC:    k <= k + 2'd1;
      pnew_pkg::B_X:      x <= 50'(beta_value) * 50'(d);
      pnew_pkg::B_LERP: begin
        big  <= (x[49:20] != '0);
        hi_q <= t_hi;
        lerp <= 37'(t_hi - t_lo) * 37'(frac);
      end
      pnew_pkg::B_GAMMA:  gw <= 33'(gamma_scale) * 33'(e_val);
      pnew_pkg::B_WEIGHT: begin
        res[k] <= w_val;
        k      <= k + 2'd1;
      end
      pnew_pkg::B_DWAIT:  if (div_done) beta_res <= quo_sat;
      default:            ;
    endcase
  end

  // frame statistics and beta
  always_ff @(posedge clk) begin
    if (rst) begin
      distance_sum <= '0;
      pair_count   <= '0;
      beta_value   <= '0;
    end else begin
      if (state == pnew_pkg::B_ACC) begin
        distance_sum <= sum_add[48] ? '1 : sum_add[47:0];
        if (pair_count != '1) pair_count <= pair_count + pnew_pkg::PAIR_W'(1);
      end
      if (state == pnew_pkg::B_DSTART && distance_sum == '0) begin
        beta_value   <= '0;
        distance_sum <= '0;
        pair_count   <= '0;
      end
      if (state == pnew_pkg::B_DWAIT && div_done) begin
        beta_value   <= quo_sat;
        distance_sum <= '0;
        pair_count   <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {beta_res, res[3], res[2], res[1], res[0]};
      m_tuser <= beta_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/pixel_neighbor_edge_weights.sv =====
// Flow: the front accepts a word, reads the line store twice and hands off to
//   the back, which fetches it, then per neighbour takes a distance step, plus an
//   accumulate step (measure word) or x, lerp, gamma and weight steps (weight
//   word) when present, then outputs; the beta divide on the last word of a
//   measure pass comes before output. Each side finishes one word before taking
//   the next; the queue lets the front run ahead of the back.
// Reset: control, counters, held pixels and beta clear; width 1024, gamma 50.0.
//   Line store contents stay undefined until written; no clearing pass.
module pixel_neighbor_edge_weights #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic         clk,
  input  logic         rst,
  // input words
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // red[7:0], green[15:8], blue[23:16]
  input  logic         s_tuser,   // cmd: 0 measure, 1 weight
  input  logic         s_tlast,   // last_in_frame
  // result words
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,   // weight_left, weight_upleft, weight_up,
                                  // weight_upright (24 each), beta_out (32)
  output logic         m_tuser,   // beta_ready
  // configuration
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [pnew_pkg::IWIDTH_W-1:0] image_width;
  logic [pnew_pkg::GAMMA_W-1:0]  gamma_scale;

  pnew_pkg::item_t front_item;
  pnew_pkg::item_t head_item;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  // configuration registers; the user must write them only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd1024;
      gamma_scale <= 16'd12800;
    end else if (cfg_we) begin
      case (cfg_index)
        pnew_pkg::REG_IMAGE_WIDTH: image_width <= cfg_data[pnew_pkg::IWIDTH_W-1:0];
        pnew_pkg::REG_GAMMA_SCALE: gamma_scale <= cfg_data;
        default:                   ;
      endcase
    end
  end

  // front: neighbour gathering from the line store and held pixels
  pnew_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .s_tlast     (s_tlast),
    .image_width (image_width),
    .full        (full),
    .push        (push),
    .item        (front_item)
  );

  // two-entry queue lets front and back stall apart
  pnew_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (front_item),
    .pop     (pop),
    .head    (head_item),
    .full    (full),
    .empty   (empty)
  );

  // back: distances, accumulation, beta divide, exp and weights
  pnew_back u_back (
    .clk         (clk),
    .rst         (rst),
    .gamma_scale (gamma_scale),
    .empty       (empty),
    .head        (head_item),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !empty)
    else $error("queue read while empty");

  a_beta_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata[127:96] == 32'd0))
    else $error("beta shown without beta_ready");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("front took a word while busy");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

  localparam bit CMD_MEASURE = 1'b0;
  localparam bit CMD_WEIGHT  = 1'b1;

  localparam int COLOUR_RANDOM   = 0;
  localparam int COLOUR_EXTREME  = 1;
  localparam int COLOUR_FLAT     = 2;
  localparam int COLOUR_NEAR     = 3;

  localparam int PASS_MEASURE = 0;
  localparam int PASS_WEIGHT  = 1;
  localparam int PASS_MIXED   = 2;

  localparam int CYCLE_LIMIT = 1500000;
  localparam int TAIL_CYCLES = 200;

  // Expected word on the result side
  typedef struct packed {
    bit [23:0] w_left;
    bit [23:0] w_upleft;
    bit [23:0] w_up;
    bit [23:0] w_upright;
    bit [31:0] beta;
    bit        beta_ready;
  } edge_word_t;

  // Edge weight predictor and store of expected words
  class edge_weight_board;
    bit [16:0]  exp_lut [0:256];
    bit [23:0]  row_mem [0:1023];
    bit [23:0]  left_px, upleft_px;
    int unsigned col;
    bit         below_top;
    bit [47:0]  dist_acc;
    bit [22:0]  pairs;
    bit [31:0]  beta;
    bit [10:0]  width_reg;
    bit [15:0]  gamma_reg;
    edge_word_t expected_q [$];
    int         errors;

    function new();
      bit [63:0] h, term, eh, q, cur;
      h    = (64'd1 << 34) / 64'd256;
      term = 64'd1 << 30;
      eh   = term;
      for (int n = 1; n <= 24; n++) begin
        term = ((term * h) >> 30) / 64'(n);
        eh   = eh + term;
      end
      q   = ((64'd1 << 60) + eh / 2) / eh;
      cur = 64'd1 << 30;
      exp_lut[0] = 17'((cur + 64'd8192) >> 14);
      for (int k = 1; k <= 256; k++) begin
        cur        = (cur * q + (64'd1 << 29)) >> 30;
        exp_lut[k] = 17'((cur + 64'd8192) >> 14);
      end
      foreach (row_mem[i]) row_mem[i] = '0;
      left_px   = '0;
      upleft_px = '0;
      col       = 0;
      below_top = 1'b0;
      dist_acc  = '0;
      pairs     = '0;
      beta      = '0;
      width_reg = 11'd1024;
      gamma_reg = 16'd12800;
      errors    = 0;
    endfunction

    function void set_reg(bit idx, bit [15:0] val);
      if (idx == pnew_pkg::REG_IMAGE_WIDTH) width_reg = val[10:0];
      else                                  gamma_reg = val;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit [31:0] colour_dist(bit [23:0] a, bit [23:0] b);
      int x;
      bit [31:0] d;
      d = 0;
      for (int s = 0; s < 24; s += 8) begin
        x = int'(a[s +: 8]) - int'(b[s +: 8]);
        d += 32'(x * x);
      end
      return d;
    endfunction

    function bit [16:0] decay(bit [31:0] d);
      bit [63:0] x, p, f, hi, lo;
      x = 64'(beta) * 64'(d);
      if (x >= (64'd16 << 16)) return '0;
      p  = x * 64'd256;
      f  = p & 64'hFFFFF;
      hi = exp_lut[p >> 20];
      lo = exp_lut[(p >> 20) + 1];
      return 17'(hi - (((hi - lo) * f) >> 20));
    endfunction

    function bit [23:0] edge_weight(bit [31:0] d, bit diag);
      bit [63:0] gw;
      gw = 64'(gamma_reg) * 64'(decay(d));
      return diag ? 24'((gw * 64'(pnew_pkg::INV_SQRT2_Q16)) >> 24) : 24'(gw >> 8);
    endfunction

    // Note an accepted pixel: update neighbour state, queue its result word
    function void note_pixel(bit cmd, bit [7:0] r, bit [7:0] g, bit [7:0] b, bit last);
      int unsigned w, c;
      bit [23:0] px, up;
      bit [23:0] nb [4];
      bit        has [4];
      bit [23:0] res [4];
      bit [31:0] d;
      bit [63:0] quot;
      edge_word_t ew;
      px = {r, g, b};
      w  = width_reg;
      if (w < 2) w = 2;
      if (w > 1024) w = 1024;
      c = (col > w - 1) ? w - 1 : col;
      up = row_mem[c];
      has[0] = c > 0;
      has[2] = below_top;
      has[1] = has[2] && has[0];
      has[3] = has[2] && (c < w - 1);
      nb[0] = left_px;
      nb[1] = upleft_px;
      nb[2] = up;
      nb[3] = has[3] ? row_mem[c + 1] : '0;
      for (int k = 0; k < 4; k++) begin
        res[k] = '0;
        if (has[k]) begin
          d = colour_dist(px, nb[k]);
          if (cmd == CMD_WEIGHT) begin
            res[k] = edge_weight(d, k[0]);
          end else begin
            dist_acc = (49'(dist_acc) + 49'(d) > 49'(48'hFFFF_FFFF_FFFF)) ?
                       48'hFFFF_FFFF_FFFF : dist_acc + 48'(d);
            if (pairs != '1) pairs++;
          end
        end
      end
      ew = '{res[0], res[1], res[2], res[3], 32'd0, 1'b0};
      row_mem[c] = px;
      upleft_px  = up;
      left_px    = px;
      if (c >= w - 1) begin
        col       = 0;
        below_top = 1'b1;
      end else begin
        col = c + 1;
      end
      if (last) begin
        if (cmd == CMD_MEASURE) begin
          quot = 0;
          if (dist_acc != 0) begin
            quot = (64'(pairs) << 16) / (64'(dist_acc) * 2);
            if (quot > 64'hFFFF_FFFF) quot = 64'hFFFF_FFFF;
          end
          beta          = 32'(quot);
          ew.beta       = beta;
          ew.beta_ready = 1'b1;
          dist_acc      = '0;
          pairs         = '0;
        end
        col       = 0;
        below_top = 1'b0;
        left_px   = '0;
        upleft_px = '0;
      end
      expected_q.push_back(ew);
    endfunction

    function void compare_field(string name, bit [31:0] exp_v, bit [31:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
      end
    endfunction

    // Check one accepted result word against the oldest expectation
    function void check_result(logic [127:0] data, logic user);
      edge_word_t ew;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word: expected none, actual %h/%b",
                 $time, data, user);
        return;
      end
      ew = expected_q.pop_front();
      compare_field("weight_left",    ew.w_left,     data[23:0]);
      compare_field("weight_upleft",  ew.w_upleft,   data[47:24]);
      compare_field("weight_up",      ew.w_up,       data[71:48]);
      compare_field("weight_upright", ew.w_upright,  data[95:72]);
      compare_field("beta_out",       ew.beta,       data[127:96]);
      compare_field("beta_ready",     ew.beta_ready, user);
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [23:0]  s_tdata;
  logic         s_tuser;
  logic         s_tlast;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;
  logic         m_tuser;
  logic         cfg_we;
  logic         cfg_index;
  logic [15:0]  cfg_data;

  edge_weight_board board;
  int unsigned cycles;
  int          hold_cycles;  // receiver hold-off, counted down by the receiver
  bit          no_idle;      // both sides run flat out while set
  int          pixels_sent;

  pixel_neighbor_edge_weights i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Watchdog: give up well beyond the slowest legal run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stalls, a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      m_tready    <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      m_tready <= no_idle || ($urandom_range(99) >= 8);
    end
  end

  // Monitor both handshakes on the pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready)
        board.note_pixel(s_tuser, s_tdata[7:0], s_tdata[15:8], s_tdata[23:16], s_tlast);
      if (m_tvalid && m_tready)
        board.check_result(m_tdata, m_tuser);
    end
  end

  // Offer one pixel word and hold it until accepted
  task automatic send_pixel(bit cmd, bit [7:0] r, bit [7:0] g, bit [7:0] b, bit last);
    while (!no_idle && $urandom_range(99) < 8) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    s_tuser  <= cmd;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  // Drop valid and wait until every expected word has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(bit idx, bit [15:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, val);
  endtask

  // One frame of n pixels, ending with last_in_frame
  task automatic run_frame(int n, int pass, int colour, bit last_measure = 1'b0);
    bit       cmd;
    bit [7:0] r, g, b, base;
    base = 8'($urandom_range(20, 235));
    for (int i = 0; i < n; i++) begin
      case (pass)
        PASS_MEASURE: cmd = CMD_MEASURE;
        PASS_WEIGHT:  cmd = CMD_WEIGHT;
        default:      cmd = bit'($urandom_range(1));
      endcase
      if (last_measure && i == n - 1) cmd = CMD_MEASURE;
      case (colour)
        COLOUR_EXTREME: begin
          r = $urandom_range(1) ? 8'hFF : 8'h00;
          g = $urandom_range(1) ? 8'hFF : 8'h00;
          b = $urandom_range(1) ? 8'hFF : 8'h00;
        end
        COLOUR_FLAT: begin
          r = base;
          g = base;
          b = base;
        end
        COLOUR_NEAR: begin
          r = base + 8'($urandom_range(0, 6)) - 8'd3;
          g = base + 8'($urandom_range(0, 6)) - 8'd3;
          b = base + 8'($urandom_range(0, 6)) - 8'd3;
        end
        default: begin
          r = 8'($urandom);
          g = 8'($urandom);
          b = 8'($urandom);
        end
      endcase
      send_pixel(cmd, r, g, b, i == n - 1);
    end
  endtask

  initial begin
    int unsigned w, n, sel, phase;
    int          colour;
    board       = new();
    cycles      = 0;
    hold_cycles = 0;
    no_idle     = 1'b0;
    pixels_sent = 0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    s_tlast     = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = pnew_pkg::REG_IMAGE_WIDTH;
    cfg_data    = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: lone pixel (no pairs, zero sum), then small widths at the extremes
    run_frame(1, PASS_MEASURE, COLOUR_RANDOM);
    write_reg(pnew_pkg::REG_IMAGE_WIDTH, 16'd0);       // acts as 2
    write_reg(pnew_pkg::REG_GAMMA_SCALE, 16'hFFFF);
    run_frame(6, PASS_MEASURE, COLOUR_FLAT);           // zero distance sum
    run_frame(5, PASS_WEIGHT, COLOUR_EXTREME);
    write_reg(pnew_pkg::REG_IMAGE_WIDTH, 16'd3);
    run_frame(7, PASS_MEASURE, COLOUR_EXTREME);
    run_frame(6, PASS_MIXED, COLOUR_EXTREME);
    write_reg(pnew_pkg::REG_IMAGE_WIDTH, 16'd1);
    write_reg(pnew_pkg::REG_GAMMA_SCALE, 16'd0);
    run_frame(4, PASS_WEIGHT, COLOUR_RANDOM);

    // Widest row: width beyond the line store clamps to its depth; no idling
    write_reg(pnew_pkg::REG_IMAGE_WIDTH, 16'd2047);
    write_reg(pnew_pkg::REG_GAMMA_SCALE, 16'd12800);
    no_idle = 1'b1;
    run_frame(1030, PASS_MIXED, COLOUR_RANDOM, 1'b1);
    no_idle = 1'b0;
    write_reg(pnew_pkg::REG_IMAGE_WIDTH, 16'd1024);
    run_frame(3, PASS_WEIGHT, COLOUR_RANDOM);

    // Random frames: mostly measure then weight on the same width
    phase = 0;
    while (pixels_sent < 1150) begin
      sel = $urandom_range(99);
      if (sel < 70)      w = $urandom_range(2, 8);
      else if (sel < 80) w = $urandom_range(0, 1);
      else               w = $urandom_range(9, 40);
      write_reg(pnew_pkg::REG_IMAGE_WIDTH, 16'(w));
      sel = $urandom_range(9);
      write_reg(pnew_pkg::REG_GAMMA_SCALE,
                sel == 0 ? 16'd0 : sel == 1 ? 16'hFFFF : 16'($urandom));
      if (w < 2) w = 2;
      n      = $urandom_range(1, w * 4 > 120 ? 120 : w * 4);
      colour = $urandom_range(3);
      if (phase == 0) begin
        // Hold the receiver off while words keep coming, so the input stalls
        hold_cycles = 400;
        n = 40;
      end
      run_frame(n, PASS_MEASURE, colour);
      run_frame(n, PASS_WEIGHT, colour);
      if ($urandom_range(3) == 0)
        run_frame($urandom_range(1, n), PASS_MIXED, $urandom_range(3));
      phase++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (board.pending() != 0)
        $display("%0t: %0d expected words never arrived", $time, board.pending());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
